// ===== design/ghp_pkg.sv =====
`default_nettype none
package ghp_pkg;

  localparam int OUT_IDX_W = 6;
  localparam int REQ_IDX_W = 8;

  typedef enum logic [2:0] {
    MODE_CREATE  = 3'd0,
    MODE_UPDATE  = 3'd1,
    MODE_GET     = 3'd2,
    MODE_EXIST   = 3'd3,
    MODE_DESTROY = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage
`default_nettype wire

// ===== design/ghp_mem.sv =====
`default_nettype none
module ghp_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 49
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/ghp_alloc.sv =====
`default_nettype none
module ghp_alloc #(
  parameter int SLOTS = 64
) (
  input  wire logic [SLOTS-1:0]         alive_i,
  output logic      [$clog2(SLOTS)-1:0] free_idx_o,
  output logic                          full_o
);

  localparam int IW = $clog2(SLOTS);

  // lowest slot that is not alive
  always_comb begin
    free_idx_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!alive_i[i]) begin
        free_idx_o = IW'(i);
      end
    end
    full_o = &alive_i;
  end

endmodule
`default_nettype wire

// ===== design/generational_handle_pool.sv =====
// Generational handle pool.
// Command port: an item (mode_i, req_index_i, req_generation_i, in_data_i,
// in_dirty_i) is taken at a rising edge with start high and busy low.
// Modes: create, update, get, exist, destroy, clear all.
// Each item gives exactly one result on status_o, out_index_o,
// out_generation_o, out_data_o and out_dirty_o, marked by done_o for one
// cycle; the receiver has no way to stall it.
// The slot entry is read from the slot RAM at the accept edge, the
// following cycle checks the handle and writes back, and the result appears
// in the cycle after that. busy is high for that one execute cycle, and no
// new item is taken until the read-modify-write of the slot RAM is done.
// A new item may be taken while done_o is shown.
// Alive and generation-valid bits sit in flip-flops and are cleared by reset
// and by clear all; no clearing pass is needed and the block accepts items
// right after reset.
`default_nettype none
module generational_handle_pool
  import ghp_pkg::*;
#(
  parameter int SLOTS     = 64,
  parameter int GEN_BITS  = 16,
  parameter int DATA_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           mode_i,
  input  wire logic [REQ_IDX_W-1:0] req_index_i,
  input  wire logic [GEN_BITS-1:0]  req_generation_i,
  input  wire logic [DATA_BITS-1:0] in_data_i,
  input  wire logic                 in_dirty_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic [OUT_IDX_W-1:0]      out_index_o,
  output logic [GEN_BITS-1:0]       out_generation_o,
  output logic [DATA_BITS-1:0]      out_data_o,
  output logic                      out_dirty_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int MW = GEN_BITS + DATA_BITS + 1;

  state_e state_q, state_d;

  logic                 accept;
  logic [IW-1:0]        free_idx;
  logic                 full;
  logic [IW-1:0]        rd_addr;

  logic [2:0]           mode_q;
  logic [GEN_BITS-1:0]  gen_q;
  logic [DATA_BITS-1:0] data_q;
  logic                 dirty_q;
  logic [IW-1:0]        addr_q;
  logic                 in_range_q;

  logic [SLOTS-1:0]     alive_q;
  logic [SLOTS-1:0]     gen_vld_q;

  logic [MW-1:0]        rdata;
  logic [MW-1:0]        wdata;
  logic                 we;

  logic [GEN_BITS-1:0]  stored_gen;
  logic [GEN_BITS-1:0]  gen_inc;
  logic [GEN_BITS-1:0]  new_gen;
  logic                 handle_ok;
  logic                 alive_set;
  logic                 alive_clr;
  logic                 clr_all;
  logic [IW+OUT_IDX_W-1:0] idx_ext;

  status_e              status_d;
  logic [OUT_IDX_W-1:0] oidx_d;
  logic [GEN_BITS-1:0]  ogen_d;
  logic [DATA_BITS-1:0] odata_d;
  logic                 odirty_d;

  logic                 done_q;
  status_e              status_q;
  logic [OUT_IDX_W-1:0] oidx_q;
  logic [GEN_BITS-1:0]  ogen_q;
  logic [DATA_BITS-1:0] odata_q;
  logic                 odirty_q;

  assign busy   = (state_q == S_EXEC);
  assign accept = start && !busy;

  ghp_alloc #(
    .SLOTS(SLOTS)
  ) u_alloc (
    .alive_i   (alive_q),
    .free_idx_o(free_idx),
    .full_o    (full)
  );

  assign rd_addr = (mode_i == MODE_CREATE) ? free_idx : req_index_i[IW-1:0];

  ghp_mem #(
    .DEPTH(SLOTS),
    .WIDTH(MW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr_q),
    .wdata_i(wdata),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= mode_i;
      gen_q      <= req_generation_i;
      data_q     <= in_data_i;
      dirty_q    <= in_dirty_i;
      addr_q     <= rd_addr;
      in_range_q <= ({1'b0, req_index_i} < (REQ_IDX_W + 1)'(SLOTS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // execute: check handle, modify, write back
  always_comb begin
    state_d    = state_q;
    stored_gen = gen_vld_q[addr_q] ? rdata[DATA_BITS+1 +: GEN_BITS] : '0;
    gen_inc    = stored_gen + GEN_BITS'(1);
    new_gen    = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
    handle_ok  = (gen_q != '0) && in_range_q && alive_q[addr_q] && (stored_gen == gen_q);
    idx_ext    = {{OUT_IDX_W{1'b0}}, addr_q};
    we         = 1'b0;
    wdata      = rdata;
    alive_set  = 1'b0;
    alive_clr  = 1'b0;
    clr_all    = 1'b0;
    status_d   = ST_OK;
    oidx_d     = '0;
    ogen_d     = '0;
    odata_d    = '0;
    odirty_d   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (mode_q)
          MODE_CREATE: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              we        = 1'b1;
              wdata     = {new_gen, data_q, dirty_q};
              alive_set = 1'b1;
              oidx_d    = idx_ext[OUT_IDX_W-1:0];
              ogen_d    = new_gen;
            end
          end
          MODE_UPDATE: begin
            if (handle_ok) begin
              we    = 1'b1;
              wdata = {stored_gen, data_q, 1'b1};
            end else begin
              status_d = ST_INVALID;
            end
          end
          MODE_GET: begin
            if (handle_ok) begin
              odata_d  = rdata[1 +: DATA_BITS];
              odirty_d = rdata[0];
            end else begin
              status_d = ST_INVALID;
            end
          end
          MODE_EXIST: begin
            if (!handle_ok) begin
              status_d = ST_INVALID;
            end
          end
          MODE_DESTROY: begin
            if (handle_ok) begin
              alive_clr = 1'b1;
            end else begin
              status_d = ST_INVALID;
            end
          end
          MODE_CLEAR: begin
            clr_all = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // alive and generation-valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q   <= '0;
      gen_vld_q <= '0;
    end else if (clr_all) begin
      alive_q   <= '0;
      gen_vld_q <= '0;
    end else begin
      if (alive_set) begin
        alive_q[addr_q]   <= 1'b1;
        gen_vld_q[addr_q] <= 1'b1;
      end
      if (alive_clr) begin
        alive_q[addr_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      status_q <= status_d;
      oidx_q   <= oidx_d;
      ogen_q   <= ogen_d;
      odata_q  <= odata_d;
      odirty_q <= odirty_d;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign out_index_o      = oidx_q;
  assign out_generation_o = ogen_q;
  assign out_data_o       = odata_q;
  assign out_dirty_o      = odirty_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not enter execute");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o)
    else $error("execute cycle gave no result");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_full_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == ST_FULL)) |-> (&alive_q))
    else $error("pool full reported with a free slot");

endmodule
`default_nettype wire

// ===== dv/generational_handle_pool_tb.sv =====
`default_nettype none
module generational_handle_pool_tb
  import ghp_pkg::*;
();

  localparam int SLOTS       = 64;
  localparam int GEN_W       = 16;
  localparam int DATA_W      = 32;
  localparam int RAND_ITEMS  = 1400;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]           mode;
    logic [REQ_IDX_W-1:0] idx;
    logic [GEN_W-1:0]     gen;
    logic [DATA_W-1:0]    data;
    logic                 dirty;
  } pool_cmd_t;

  typedef struct packed {
    status_e              status;
    logic [OUT_IDX_W-1:0] index;
    logic [GEN_W-1:0]     gen;
    logic [DATA_W-1:0]    data;
    logic                 dirty;
  } pool_reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [2:0]           mode_i = '0;
  logic [REQ_IDX_W-1:0] req_index_i = '0;
  logic [GEN_W-1:0]     req_generation_i = '0;
  logic [DATA_W-1:0]    in_data_i = '0;
  logic                 in_dirty_i = 1'b0;
  logic                 done_o;
  logic [1:0]           status_o;
  logic [OUT_IDX_W-1:0] out_index_o;
  logic [GEN_W-1:0]     out_generation_o;
  logic [DATA_W-1:0]    out_data_o;
  logic                 out_dirty_o;

  generational_handle_pool DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .req_index_i      (req_index_i),
    .req_generation_i (req_generation_i),
    .in_data_i        (in_data_i),
    .in_dirty_i       (in_dirty_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .out_index_o      (out_index_o),
    .out_generation_o (out_generation_o),
    .out_data_o       (out_data_o),
    .out_dirty_o      (out_dirty_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the slot pool
  bit                alive_tab   [SLOTS];
  logic [GEN_W-1:0]  gen_tab     [SLOTS];
  logic [DATA_W-1:0] payload_tab [SLOTS];
  bit                dirty_tab   [SLOTS];

  pool_cmd_t   cmd_q [$];
  pool_reply_t reply_q [$];
  pool_cmd_t   cur_cmd;
  pool_reply_t seen_reply;
  int          send_idle_pct = 25;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          item_cnt = 0;
  int          create_cnt = 0;
  int          full_cnt = 0;
  int          invalid_cnt = 0;

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      alive_tab[s]   = 1'b0;
      gen_tab[s]     = '0;
      payload_tab[s] = '0;
      dirty_tab[s]   = 1'b0;
    end
  end

  function automatic pool_reply_t apply_cmd(pool_cmd_t c);
    pool_reply_t r;
    logic [5:0]  slot;
    logic        hit;
    r    = '0;
    slot = c.idx[5:0];
    hit  = (c.gen != '0) && (c.idx < SLOTS) && alive_tab[slot] && (gen_tab[slot] == c.gen);
    case (c.mode)
      MODE_CREATE: begin
        r.status = ST_FULL;
        for (int s = 0; s < SLOTS; s++) begin
          if (!alive_tab[s] && r.status == ST_FULL) begin
            gen_tab[s] = gen_tab[s] + 1'b1;
            if (gen_tab[s] == '0) begin
              gen_tab[s] = 1;
            end
            payload_tab[s] = c.data;
            dirty_tab[s]   = c.dirty;
            alive_tab[s]   = 1'b1;
            r.status = ST_OK;
            r.index  = 6'(s);
            r.gen    = gen_tab[s];
          end
        end
        if (r.status == ST_FULL) full_cnt++;
        else create_cnt++;
      end
      MODE_UPDATE, MODE_GET, MODE_EXIST, MODE_DESTROY: begin
        if (!hit) begin
          r.status = ST_INVALID;
          invalid_cnt++;
        end else if (c.mode == MODE_UPDATE) begin
          payload_tab[slot] = c.data;
          dirty_tab[slot]   = 1'b1;
        end else if (c.mode == MODE_GET) begin
          r.data  = payload_tab[slot];
          r.dirty = dirty_tab[slot];
        end else if (c.mode == MODE_DESTROY) begin
          alive_tab[slot]   = 1'b0;
          payload_tab[slot] = '0;
          dirty_tab[slot]   = 1'b0;
        end
      end
      MODE_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) begin
          alive_tab[s]   = 1'b0;
          gen_tab[s]     = '0;
          payload_tab[s] = '0;
          dirty_tab[s]   = 1'b0;
        end
      end
      default: ;
    endcase
    item_cnt++;
    return r;
  endfunction

  task automatic send_cmd(logic [2:0] m, logic [REQ_IDX_W-1:0] i, logic [GEN_W-1:0] g,
                          logic [DATA_W-1:0] d, logic dy);
    while (cmd_q.size() >= 2) @(negedge clk_i);
    cmd_q.push_back('{m, i, g, d, dy});
  endtask

  task automatic check_field(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h, got %h", $time, what, want, got);
      err_cnt++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) reply_q.push_back(apply_cmd(cur_cmd));
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = cmd_q.pop_front();
        start            <= 1'b1;
        mode_i           <= cur_cmd.mode;
        req_index_i      <= cur_cmd.idx;
        req_generation_i <= cur_cmd.gen;
        in_data_i        <= cur_cmd.data;
        in_dirty_i       <= cur_cmd.dirty;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        $display("%0t result with no item outstanding: expected none, got status %h",
                 $time, status_o);
        err_cnt++;
      end else begin
        seen_reply = reply_q.pop_front();
        check_field("status", 32'(seen_reply.status), 32'(status_o));
        check_field("out_index", 32'(seen_reply.index), 32'(out_index_o));
        check_field("out_generation", 32'(seen_reply.gen), 32'(out_generation_o));
        check_field("out_data", seen_reply.data, out_data_o);
        check_field("out_dirty", 32'(seen_reply.dirty), 32'(out_dirty_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    pool_cmd_t            c;
    int                   pick;
    int                   live_n;
    logic [REQ_IDX_W-1:0] live_list [SLOTS];
    logic [REQ_IDX_W-1:0] slot;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    send_cmd(MODE_GET, '0, '0, '0, 1'b0);
    send_cmd(MODE_EXIST, 8'hFF, 16'hFFFF, '0, 1'b0);
    send_cmd(MODE_CREATE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(MODE_CREATE, '0, '0, '0, 1'b0);
    send_cmd(MODE_GET, 8'd0, 16'd1, '0, 1'b0);
    send_cmd(MODE_UPDATE, 8'd1, 16'd1, 32'h8000_0001, 1'b0);
    send_cmd(MODE_GET, 8'd1, 16'd1, '0, 1'b0);
    send_cmd(MODE_EXIST, 8'd1, 16'd2, '0, 1'b0);
    send_cmd(MODE_UPDATE, 8'd1, 16'd0, 32'h1234_5678, 1'b1);
    send_cmd(MODE_UPDATE, 8'd65, 16'd1, 32'h1234_5678, 1'b1);
    send_cmd(MODE_DESTROY, 8'd0, 16'd1, '0, 1'b0);
    send_cmd(MODE_GET, 8'd0, 16'd1, '0, 1'b0);
    send_cmd(MODE_DESTROY, 8'd0, 16'd1, '0, 1'b0);
    send_cmd(MODE_CREATE, 8'd0, 16'd0, 32'h0000_00A5, 1'b0);
    send_cmd(MODE_EXIST, 8'd0, 16'd2, '0, 1'b0);
    send_cmd(MODE_SPARE_LO, 8'd1, 16'd1, 32'hFFFF_FFFF, 1'b1);
    send_cmd(MODE_SPARE_HI, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(MODE_CLEAR, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(MODE_EXIST, 8'd1, 16'd1, '0, 1'b0);
    send_cmd(MODE_CREATE, 8'd0, 16'd0, 32'h5A5A_5A5A, 1'b1);

    // random traffic, mostly live handles
    send_idle_pct = 25;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) send_idle_pct = 82;
      if (n == 2 * RAND_ITEMS / 3) send_idle_pct = 0;
      live_n = 0;
      for (int s = 0; s < SLOTS; s++) begin
        if (alive_tab[s]) begin
          live_list[live_n] = 8'(s);
          live_n++;
        end
      end
      c.mode  = MODE_CREATE;
      c.idx   = 8'($urandom);
      c.gen   = 16'($urandom);
      c.data  = $urandom;
      c.dirty = 1'($urandom);
      pick = $urandom_range(999);
      if (pick < 350 || (pick < 750 && live_n == 0)) begin
        c.mode = MODE_CREATE;
      end else if (pick < 750) begin
        c.mode = 3'(MODE_UPDATE + $urandom_range(3));
        c.idx  = live_list[$urandom_range(live_n - 1)];
        c.gen  = gen_tab[c.idx[5:0]];
      end else if (pick < 900) begin
        c.mode = 3'(MODE_UPDATE + $urandom_range(3));
        slot   = (live_n != 0) ? live_list[$urandom_range(live_n - 1)]
                               : 8'($urandom_range(SLOTS - 1));
        c.idx  = slot;
        c.gen  = gen_tab[slot[5:0]];
        case ($urandom_range(3))
          0: c.gen = '0;
          1: c.gen = c.gen + 16'($urandom_range(3, 1));
          2: c.idx = 8'($urandom_range(255, SLOTS));
          default: c.idx = 8'($urandom_range(SLOTS - 1));
        endcase
      end else if (pick < 903) begin
        c.mode = MODE_CLEAR;
      end else if (pick < 940) begin
        c.mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
      end else begin
        c.mode = 3'($urandom_range(7));
        if (c.mode == MODE_CLEAR) c.mode = MODE_GET;
      end
      send_cmd(c.mode, c.idx, c.gen, c.data, c.dirty);
    end

    while (cmd_q.size() != 0 || start || reply_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    $display("%0d items: %0d handles issued, %0d refused as full, %0d invalid handles",
             item_cnt, create_cnt, full_cnt, invalid_cnt);
    $display("sender idle mix 25%%, 82%%, none; spare modes and clear all mixed in");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
